// File: hw/rtl/ppmh_pkg.sv
// ----------------------------------------------------------------------------
// ppmh_pkg
// Shared types, character codes and helpers for the P6 header parser.
// ----------------------------------------------------------------------------
package ppmh_pkg;

  localparam int TOKEN_BUFFER_DEF = 24;

  localparam logic [15:0] MAXVAL_RESET = 16'd255;
  localparam logic [16:0] VALUE_MAX    = 17'd65535;
  localparam logic [16:0] ACC_SAT      = 17'd65536;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_P6      = 3'd1,
    ST_BAD_WIDTH   = 3'd2,
    ST_BAD_HEIGHT  = 3'd3,
    ST_BAD_MAXVAL  = 3'd4,
    ST_UNSUPPORTED = 3'd5
  } status_t;

  typedef struct packed {
    logic       start_of_file;
    logic       end_of_file;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] pixel_offset;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// File: hw/rtl/ppm_p6_header_parser_top.sv
// ----------------------------------------------------------------------------
// ppm_p6_header_parser_top
// P6 header parser: one file byte or end-of-file mark per item, one status
// item with width, height and pixel offset per file.
// Throughput: one item per cycle unless out_stall holds a pending result; the parser state is registered.
// Result path: an accepted item is registered in the input stage; its result is
// registered in the result stage once that stage is free.
// Reset: synchronous active-low rst_n clears parser state and valids and
// sets required_maxval to 255; no clearing pass.
// ----------------------------------------------------------------------------
module ppm_p6_header_parser_top
  import ppmh_pkg::*;
#(
  parameter int TOKEN_BUFFER = TOKEN_BUFFER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_of_file,
  input  logic        in_end_of_file,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [31:0] out_pixel_offset,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data
);

  logic [15:0] req_maxval_r;
  item_t       in_item;
  item_t       item;
  logic        item_vld;
  logic        down_free;
  logic        step;
  logic        res_vld;
  result_t     res;
  result_t     out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_maxval_r <= MAXVAL_RESET;
    end else if (cfg_write_en) begin
      req_maxval_r <= cfg_write_data;
    end
  end

  assign in_item = '{start_of_file: in_start_of_file, end_of_file: in_end_of_file,
                     data_byte: in_data_byte};
  assign step    = item_vld && down_free;

  ppmh_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .down_free (down_free),
    .item_vld  (item_vld),
    .item      (item)
  );

  ppmh_parser #(
    .TOKEN_BUFFER (TOKEN_BUFFER)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .item            (item),
    .required_maxval (req_maxval_r),
    .res_vld         (res_vld),
    .res             (res)
  );

  ppmh_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .free      (down_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status       = out_res.status;
  assign out_image_width  = out_res.image_width;
  assign out_image_height = out_res.image_height;
  assign out_pixel_offset = out_res.pixel_offset;

  a_ok_has_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |->
      (out_image_width != '0 && out_image_height != '0 && out_pixel_offset != '0))
    else $error("ok status with empty dimensions");

  a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_image_width == '0 && out_image_height == '0 && out_pixel_offset == '0))
    else $error("failing status carries nonzero fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_UNSUPPORTED))
    else $error("status code out of range");

endmodule

// File: hw/rtl/ppmh_in_stage.sv
// ----------------------------------------------------------------------------
// ppmh_in_stage
// Input register: captures one item and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module ppmh_in_stage
  import ppmh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  down_free,
  output logic  item_vld,
  output item_t item
);

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  logic  take;

  assign in_stall = vld_r && !down_free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (down_free) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// File: hw/rtl/ppmh_parser.sv
// ----------------------------------------------------------------------------
// ppmh_parser
// Header state machine: magic check, whitespace/comment skip, token values.
// ----------------------------------------------------------------------------
module ppmh_parser
  import ppmh_pkg::*;
#(
  parameter int TOKEN_BUFFER = TOKEN_BUFFER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  item_t       item,
  input  logic [15:0] required_maxval,
  output logic        res_vld,
  output result_t     res
);

  localparam int LEN_W = $clog2(TOKEN_BUFFER);

  typedef enum logic [2:0] {
    PH_MAGIC1,
    PH_MAGIC2,
    PH_SKIP,
    PH_SKIP_COMMENT,
    PH_TOKEN,
    PH_TOKEN_COMMENT,
    PH_DONE,
    PH_MAGIC2_BAD
  } phase_t;

  phase_t             phase_r, phase_nxt, cur_phase;
  logic [1:0]         tok_num_r, tok_num_nxt, cur_tok_num;
  logic [LEN_W-1:0]   tok_len_r, tok_len_nxt, cur_tok_len;
  logic [16:0]        acc_r, acc_nxt, cur_acc;
  logic               ovf_r, ovf_nxt, cur_ovf;
  logic               neg_r, neg_nxt, cur_neg;
  logic               stop_r, stop_nxt, cur_stop;
  logic [15:0]        width_r, width_nxt, cur_width;
  logic [15:0]        height_r, height_nxt, cur_height;
  logic [31:0]        count_r, count_nxt, cur_count;

  logic [7:0]         c;
  logic [31:0]        count_new;
  logic [15:0]        fin_val;
  logic               fin_bad;
  result_t            fin_res;
  logic               take_ok;
  logic               is_sign;
  logic               is_dig;
  logic [20:0]        acc_mul;
  logic [LEN_W:0]     len_inc;

  function automatic status_t fail_code(input logic [1:0] tn);
    case (tn)
      2'd0:    return ST_BAD_WIDTH;
      2'd1:    return ST_BAD_HEIGHT;
      default: return ST_BAD_MAXVAL;
    endcase
  endfunction

  // clear on start of file before handling the item
  always_comb begin
    if (item.start_of_file) begin
      cur_phase   = PH_MAGIC1;
      cur_tok_num = '0;
      cur_tok_len = '0;
      cur_acc     = '0;
      cur_ovf     = 1'b0;
      cur_neg     = 1'b0;
      cur_stop    = 1'b0;
      cur_width   = '0;
      cur_height  = '0;
      cur_count   = '0;
    end else begin
      cur_phase   = phase_r;
      cur_tok_num = tok_num_r;
      cur_tok_len = tok_len_r;
      cur_acc     = acc_r;
      cur_ovf     = ovf_r;
      cur_neg     = neg_r;
      cur_stop    = stop_r;
      cur_width   = width_r;
      cur_height  = height_r;
      cur_count   = count_r;
    end
  end

  assign c = item.data_byte;

  always_comb begin
    count_new = cur_count;
    if (!item.end_of_file && (cur_count != '1)) begin
      count_new = cur_count + 32'd1;
    end
  end

  always_comb begin
    fin_val = cur_acc[15:0];
    if (cur_ovf || cur_neg || (cur_acc > VALUE_MAX)) begin
      fin_val = '0;
    end
    fin_bad = (cur_width == '0) || (cur_height == '0) || (fin_val == '0) ||
              (fin_val != required_maxval);
    if (fin_bad) begin
      fin_res = '{status: ST_UNSUPPORTED, image_width: '0, image_height: '0,
                  pixel_offset: '0};
    end else begin
      fin_res = '{status: ST_OK, image_width: cur_width, image_height: cur_height,
                  pixel_offset: count_new};
    end
  end

  assign len_inc = {1'b0, cur_tok_len} + (LEN_W+1)'(1);
  assign take_ok = len_inc < (LEN_W+1)'(TOKEN_BUFFER);
  assign is_sign = (cur_tok_len == '0) && ((c == CH_PLUS) || (c == CH_MINUS));
  assign is_dig  = !cur_stop && is_digit(c);
  assign acc_mul = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0} +
                   {13'd0, c - CH_ZERO};

  always_comb begin
    phase_nxt   = phase_r;
    tok_num_nxt = tok_num_r;
    tok_len_nxt = tok_len_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    neg_nxt     = neg_r;
    stop_nxt    = stop_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    count_nxt   = count_r;
    res_vld     = 1'b0;
    res         = '{status: ST_NOT_P6, image_width: '0, image_height: '0,
                    pixel_offset: '0};
    if (step) begin
      phase_nxt   = cur_phase;
      tok_num_nxt = cur_tok_num;
      tok_len_nxt = cur_tok_len;
      acc_nxt     = cur_acc;
      ovf_nxt     = cur_ovf;
      neg_nxt     = cur_neg;
      stop_nxt    = cur_stop;
      width_nxt   = cur_width;
      height_nxt  = cur_height;
      count_nxt   = count_new;
      if (cur_phase != PH_DONE) begin
        if (item.end_of_file) begin
          res_vld   = 1'b1;
          phase_nxt = PH_DONE;
          case (cur_phase)
            PH_MAGIC1, PH_MAGIC2, PH_MAGIC2_BAD: begin
              res.status = ST_NOT_P6;
            end
            PH_TOKEN: begin
              if (cur_tok_num == 2'd2) begin
                res = fin_res;
              end else begin
                res.status = fail_code(cur_tok_num + 2'd1);
              end
            end
            default: begin
              res.status = fail_code(cur_tok_num);
            end
          endcase
        end else begin
          case (cur_phase)
            PH_MAGIC1: begin
              phase_nxt = (c == CH_P) ? PH_MAGIC2 : PH_MAGIC2_BAD;
            end
            PH_MAGIC2: begin
              if (c != CH_SIX) begin
                res_vld    = 1'b1;
                res.status = ST_NOT_P6;
                phase_nxt  = PH_DONE;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
            PH_MAGIC2_BAD: begin
              res_vld    = 1'b1;
              res.status = ST_NOT_P6;
              phase_nxt  = PH_DONE;
            end
            PH_SKIP_COMMENT: begin
              if (is_eol(c)) begin
                phase_nxt = PH_SKIP;
              end
            end
            PH_SKIP, PH_TOKEN, PH_TOKEN_COMMENT: begin
              if ((cur_phase == PH_TOKEN && is_space(c)) ||
                  (cur_phase == PH_TOKEN_COMMENT && is_eol(c))) begin
                // close the token
                tok_len_nxt = '0;
                acc_nxt     = '0;
                ovf_nxt     = 1'b0;
                neg_nxt     = 1'b0;
                stop_nxt    = 1'b0;
                phase_nxt   = PH_SKIP;
                if (cur_tok_num == 2'd0) begin
                  width_nxt   = fin_val;
                  tok_num_nxt = 2'd1;
                end else if (cur_tok_num == 2'd1) begin
                  height_nxt  = fin_val;
                  tok_num_nxt = 2'd2;
                end else begin
                  res_vld   = 1'b1;
                  res       = fin_res;
                  phase_nxt = PH_DONE;
                end
              end else if (cur_phase == PH_TOKEN_COMMENT) begin
                phase_nxt = PH_TOKEN_COMMENT;
              end else if (c == CH_HASH) begin
                phase_nxt = (cur_phase == PH_SKIP) ? PH_SKIP_COMMENT : PH_TOKEN_COMMENT;
              end else if (cur_phase == PH_SKIP && is_space(c)) begin
                phase_nxt = PH_SKIP;
              end else if (!take_ok) begin
                res_vld    = 1'b1;
                res.status = fail_code(cur_tok_num);
                phase_nxt  = PH_DONE;
              end else begin
                phase_nxt   = PH_TOKEN;
                tok_len_nxt = len_inc[LEN_W-1:0];
                if (is_sign) begin
                  if (c == CH_MINUS) begin
                    neg_nxt = 1'b1;
                  end
                end else if (is_dig) begin
                  if (acc_mul > {4'd0, VALUE_MAX}) begin
                    acc_nxt = ACC_SAT;
                    ovf_nxt = 1'b1;
                  end else begin
                    acc_nxt = acc_mul[16:0];
                  end
                end else begin
                  stop_nxt = 1'b1;
                end
              end
            end
            default: begin
              phase_nxt = cur_phase;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC1;
      tok_num_r <= '0;
      tok_len_r <= '0;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      neg_r     <= 1'b0;
      stop_r    <= 1'b0;
      width_r   <= '0;
      height_r  <= '0;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      tok_num_r <= tok_num_nxt;
      tok_len_r <= tok_len_nxt;
      acc_r     <= acc_nxt;
      ovf_r     <= ovf_nxt;
      neg_r     <= neg_nxt;
      stop_r    <= stop_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      count_r   <= count_nxt;
    end
  end

  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (phase_r == PH_DONE))
    else $error("parser not idle after result");

  a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.start_of_file && phase_r == PH_DONE) |-> !res_vld)
    else $error("result emitted after header finished");

  a_token_count: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_num_r != 2'd3) && (acc_r <= ACC_SAT))
    else $error("token counter or accumulator out of range");

endmodule

// File: hw/rtl/ppmh_out_stage.sv
// ----------------------------------------------------------------------------
// ppmh_out_stage
// Result register: holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
module ppmh_out_stage
  import ppmh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_vld,
  input  result_t res,
  output logic    free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule
